// File: design/scba_pkg.sv
// Shared types and codes for the size-class block allocator.
package scba_pkg;

   localparam int IDX_W  = 10;
   localparam int CLS_W  = 3;
   localparam int SIZE_W = 16;

   // Largest request served by each pooled class.
   localparam int SMALL_MAX_WORDS  = 2;
   localparam int MEDIUM_MAX_WORDS = 8;
   localparam int LARGE_MAX_WORDS  = 64;
   localparam int POOLED_CLASSES   = 3;

   localparam logic [CLS_W-1:0] CLS_SENTINEL  = 3'd0;
   localparam logic [CLS_W-1:0] CLS_SMALL     = 3'd1;
   localparam logic [CLS_W-1:0] CLS_MEDIUM    = 3'd2;
   localparam logic [CLS_W-1:0] CLS_LARGE     = 3'd3;
   localparam logic [CLS_W-1:0] CLS_OVERSIZED = 3'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOC     = 3'd0,
      ST_SENTINEL  = 3'd1,
      ST_HEAP      = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_FREED     = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_POP
   } state_type;

   typedef struct packed {
      logic                     action;
      logic signed [SIZE_W-1:0] request_size;
      logic [CLS_W-1:0]         free_class;
      logic [IDX_W-1:0]         free_index;
   } req_word_type;

   typedef struct packed {
      status_type       status;
      logic [CLS_W-1:0] block_class;
      logic [IDX_W-1:0] block_index;
   } rsp_word_type;

   // Outcome of sorting an allocate request by size.
   typedef struct packed {
      logic             pooled;
      status_type       status;
      logic [CLS_W-1:0] block_class;
   } alloc_decode_type;

endpackage

// File: design/scba_ram.sv
// Generic single-port RAM with registered read data.
module scba_ram
   #(parameter int WIDTH = 11,
     parameter int DEPTH = 3072)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/scba_classify.sv
// Sorts an allocate request into the sentinel, a pooled class or the heap.
module scba_classify import scba_pkg::*;
   #(parameter int CLASS_COUNT = 3)
   (input  logic signed [SIZE_W-1:0] request_size,
    output alloc_decode_type         decode);

   logic [CLS_W-1:0] size_class;

   always_comb begin
      if (request_size <= SIZE_W'(SMALL_MAX_WORDS)) begin
         size_class = CLS_SMALL;
      end else if (request_size <= SIZE_W'(MEDIUM_MAX_WORDS)) begin
         size_class = CLS_MEDIUM;
      end else if (request_size <= SIZE_W'(LARGE_MAX_WORDS)) begin
         size_class = CLS_LARGE;
      end else begin
         size_class = CLS_OVERSIZED;
      end

      if (request_size <= $signed(SIZE_W'(0))) begin
         decode.pooled      = 1'b0;
         decode.status      = ST_SENTINEL;
         decode.block_class = CLS_SENTINEL;
      end else if (size_class == CLS_OVERSIZED || 32'(size_class) > 32'(CLASS_COUNT)) begin
         decode.pooled      = 1'b0;
         decode.status      = ST_HEAP;
         decode.block_class = CLS_OVERSIZED;
      end else begin
         decode.pooled      = 1'b1;
         decode.status      = ST_ALLOC;
         decode.block_class = size_class;
      end
   end

endmodule

// File: design/size_class_block_allocator_top.sv
// Top level of the size-class block allocator.
//
// Hands out and takes back blocks in three size classes (up to 2, 8 and 64
// words), each from a pool of POOL_BLOCKS blocks. An allocate that reuses a
// freed block passes through the pop state, since the next link of the free
// stack is read from the link memory before the stack head moves; busy is high
// in the pop state. Every other word takes one cycle, so start may be held high
// and a new word goes in every cycle. Each result appears with rsp_strobe one
// cycle after the block's last working cycle and must be taken then. The link
// memory needs no clearing after reset: an entry is always written before it
// is read, so the block is ready in the first cycle after reset.
module size_class_block_allocator_top import scba_pkg::*;
   #(parameter int POOL_BLOCKS = 1024,
     parameter int CLASS_COUNT = 3)
   (input  logic         clock,
    input  logic         reset,
    input  logic         start,
    output logic         busy,
    input  req_word_type req_word,
    output logic         rsp_strobe,
    output rsp_word_type rsp_word);

   localparam int SLOTS  = (CLASS_COUNT < POOLED_CLASSES) ? CLASS_COUNT : POOLED_CLASSES;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HEAD_W = $clog2(POOL_BLOCKS + 1);
   localparam int ADDR_W = $clog2(SLOTS * POOL_BLOCKS);
   localparam logic [HEAD_W-1:0] STACK_NULL = HEAD_W'(POOL_BLOCKS);

   state_type          state_ff, state_in;
   logic [HEAD_W-1:0]  heads_ff [SLOTS];
   logic [HEAD_W-1:0]  heads_in [SLOTS];
   logic [HEAD_W-1:0]  fresh_ff [SLOTS];
   logic [HEAD_W-1:0]  fresh_in [SLOTS];
   logic [SLOT_W-1:0]  pop_slot_ff, pop_slot_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type       rsp_ff, rsp_in;

   alloc_decode_type   decode;
   logic [CLS_W-1:0]   alloc_cls_m1;
   logic [CLS_W-1:0]   free_cls_m1;
   logic [SLOT_W-1:0]  alloc_slot;
   logic [SLOT_W-1:0]  free_slot;
   logic               free_ok;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [HEAD_W-1:0]  ram_wdata;
   logic [HEAD_W-1:0]  ram_rdata;

   function automatic logic [ADDR_W-1:0] link_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [HEAD_W-1:0] idx);
      link_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(POOL_BLOCKS)) + ADDR_W'(idx);
   endfunction

   scba_classify #(.CLASS_COUNT(CLASS_COUNT)) u_classify (
      .request_size (req_word.request_size),
      .decode       (decode));

   scba_ram #(.WIDTH(HEAD_W), .DEPTH(SLOTS * POOL_BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata));

   assign alloc_cls_m1 = decode.block_class - CLS_SMALL;
   assign free_cls_m1  = req_word.free_class - CLS_SMALL;
   assign alloc_slot   = alloc_cls_m1[SLOT_W-1:0];
   assign free_slot    = free_cls_m1[SLOT_W-1:0];
   assign free_ok      = (req_word.free_class != CLS_SENTINEL)
                      && (32'(req_word.free_class) <= 32'(SLOTS))
                      && (32'(req_word.free_index) < 32'(POOL_BLOCKS));

   always_comb begin
      state_in      = state_ff;
      heads_in      = heads_ff;
      fresh_in      = fresh_ff;
      pop_slot_in   = pop_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_addr      = link_addr(free_slot, HEAD_W'(req_word.free_index));
      ram_wdata     = heads_ff[free_slot];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_word.action == ACT_FREE) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.status      = ST_FREED;
                  rsp_in.block_class = req_word.free_class;
                  rsp_in.block_index = req_word.free_index;
                  if (free_ok) begin
                     // Push: the old head becomes the freed block's link.
                     ram_we              = 1'b1;
                     heads_in[free_slot] = HEAD_W'(req_word.free_index);
                  end
               end else if (!decode.pooled) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.status      = decode.status;
                  rsp_in.block_class = decode.block_class;
                  rsp_in.block_index = '0;
               end else if (heads_ff[alloc_slot] < STACK_NULL) begin
                  // Pop: the result waits for the link read in the next cycle.
                  ram_addr           = link_addr(alloc_slot, heads_ff[alloc_slot]);
                  pop_slot_in        = alloc_slot;
                  rsp_in.status      = ST_ALLOC;
                  rsp_in.block_class = decode.block_class;
                  rsp_in.block_index = IDX_W'(heads_ff[alloc_slot]);
                  state_in           = S_POP;
               end else if (fresh_ff[alloc_slot] < STACK_NULL) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_in.status        = ST_ALLOC;
                  rsp_in.block_class   = decode.block_class;
                  rsp_in.block_index   = IDX_W'(fresh_ff[alloc_slot]);
                  fresh_in[alloc_slot] = fresh_ff[alloc_slot] + HEAD_W'(1);
               end else begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.status      = ST_EXHAUSTED;
                  rsp_in.block_class = decode.block_class;
                  rsp_in.block_index = '0;
               end
            end
         end
         S_POP: begin
            heads_in[pop_slot_ff] = ram_rdata;
            rsp_strobe_in         = 1'b1;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         pop_slot_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            heads_ff[i] <= STACK_NULL;
            fresh_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pop_slot_ff   <= pop_slot_in;
         heads_ff      <= heads_in;
         fresh_ff      <= fresh_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff == S_POP);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   // A pop holds the block busy only in the pop state.
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("allocator stayed busy for more than one cycle");

   // The pop cycle always ends in a result.
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("pop finished without a result");

   // Every accepted word yields a result next cycle or enters the pop cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted word produced neither a result nor a pop");

   // A popped block is always a real block of the pool.
   a_pop_valid_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && state_in == S_POP) |-> (heads_ff[alloc_slot] < STACK_NULL))
      else $error("pop started on an empty stack");

endmodule

// File: dv/size_class_block_allocator_top_tb.sv
// Self-checking testbench for the size-class block allocator top level.
`timescale 1ns / 100ps

module size_class_block_allocator_top_tb;
   import scba_pkg::*;

   localparam int POOL_BLOCKS    = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;
   localparam int MAX_PRINTED    = 50;
   localparam int REQ_W          = $bits(req_word_type);

   typedef struct {
      req_word_type word;
      int           idle_pct;
      bit           drain;
   } stim_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   // Allocator shadow state: free stacks threaded through a link table.
   int link_mem [POOLED_CLASSES][POOL_BLOCKS];
   int stack_top [POOLED_CLASSES];
   int fresh_count [POOLED_CLASSES];

   stim_entry_type pending_words[$];
   rsp_word_type   expected_rsps[$];

   int error_count;
   int stall_cycles;
   int phase_idle_pct;
   bit drain_next;
   int large_pushes;
   int issued [POOLED_CLASSES];

   size_class_block_allocator_top #(
      .POOL_BLOCKS(POOL_BLOCKS),
      .CLASS_COUNT(POOLED_CLASSES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   // Works out the result of one accepted word and updates the shadow state.
   task automatic serve_request(input req_word_type w);
      rsp_word_type     r;
      int               n;
      int               slot;
      logic [CLS_W-1:0] cls;
      r.status      = ST_FREED;
      r.block_class = w.free_class;
      r.block_index = w.free_index;
      if (w.action == ACT_ALLOC) begin
         n = $signed(w.request_size);
         r.block_index = '0;
         if (n <= 0) begin
            r.status      = ST_SENTINEL;
            r.block_class = CLS_SENTINEL;
         end else if (n > LARGE_MAX_WORDS) begin
            r.status      = ST_HEAP;
            r.block_class = CLS_OVERSIZED;
         end else begin
            cls = (n <= SMALL_MAX_WORDS) ? CLS_SMALL :
                  (n <= MEDIUM_MAX_WORDS) ? CLS_MEDIUM : CLS_LARGE;
            slot = int'(cls) - 1;
            r.block_class = cls;
            if (stack_top[slot] < POOL_BLOCKS) begin
               r.status        = ST_ALLOC;
               r.block_index   = IDX_W'(stack_top[slot]);
               stack_top[slot] = link_mem[slot][stack_top[slot]];
            end else if (fresh_count[slot] < POOL_BLOCKS) begin
               r.status      = ST_ALLOC;
               r.block_index = IDX_W'(fresh_count[slot]);
               fresh_count[slot]++;
            end else begin
               r.status = ST_EXHAUSTED;
            end
         end
      end else if (w.free_class >= CLS_SMALL && w.free_class <= CLS_LARGE) begin
         slot = int'(w.free_class) - 1;
         link_mem[slot][w.free_index] = stack_top[slot];
         stack_top[slot] = w.free_index;
      end
      expected_rsps.push_back(r);
   endtask

   function automatic req_word_type make_alloc(input int size);
      logic [REQ_W-1:0] raw;
      req_word_type     w;
      raw = REQ_W'($urandom);
      w = raw;
      w.action       = ACT_ALLOC;
      w.request_size = SIZE_W'(size);
      return w;
   endfunction

   function automatic req_word_type make_free(input int cls, input int idx);
      logic [REQ_W-1:0] raw;
      req_word_type     w;
      raw = REQ_W'($urandom);
      w = raw;
      w.action     = ACT_FREE;
      w.free_class = CLS_W'(cls);
      w.free_index = IDX_W'(idx);
      return w;
   endfunction

   task automatic add_word(input req_word_type w);
      stim_entry_type e;
      e.word     = w;
      e.idle_pct = phase_idle_pct;
      e.drain    = drain_next;
      drain_next = 1'b0;
      if (w.action == ACT_FREE && w.free_class == CLS_LARGE) begin
         large_pushes++;
      end
      pending_words.push_back(e);
   endtask

   // Mostly allocate/free traffic within the pools, with some random noise.
   task automatic add_mixed(input int count);
      int pick;
      int c;
      int size;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         c    = $urandom_range(0, POOLED_CLASSES - 1);
         if (pick < 45) begin
            case (c)
               0: size = $urandom_range(1, SMALL_MAX_WORDS);
               1: size = $urandom_range(SMALL_MAX_WORDS + 1, MEDIUM_MAX_WORDS);
               default: size = $urandom_range(MEDIUM_MAX_WORDS + 1, LARGE_MAX_WORDS);
            endcase
            issued[c]++;
            add_word(make_alloc(size));
         end else if (pick < 80) begin
            size = (issued[c] + 2 > POOL_BLOCKS - 1) ? POOL_BLOCKS - 1 : issued[c] + 2;
            add_word(make_free(c + 1, $urandom_range(0, size)));
         end else if (pick < 90) begin
            add_word(make_alloc($urandom_range(0, 65535)));
         end else begin
            add_word(make_free($urandom_range(0, 7), $urandom_range(0, POOL_BLOCKS - 1)));
         end
      end
   endtask

   // Driver: start stays up until the word is taken, then the next word
   // goes out unless the sender decides to idle.
   always @(posedge clock) begin
      bit took;
      bit go;
      took = 1'b0;
      go   = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            serve_request(req_word);
            void'(pending_words.pop_front());
         end
         if (!(start && !took)) begin
            if (pending_words.size() > 0) begin
               if (pending_words[0].drain && expected_rsps.size() > 0) begin
                  go = 1'b0;
               end else begin
                  go = ($urandom_range(0, 99) >= pending_words[0].idle_pct);
               end
               if (go) begin
                  req_word <= pending_words[0].word;
               end
            end
            start <= go;
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_rsps.size() == 0) begin
               report_error($sformatf("result word %h with none expected", rsp_word));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_word.status !== want.status) begin
                  report_error($sformatf("status got %0d want %0d",
                                         rsp_word.status, want.status));
               end
               if (rsp_word.block_class !== want.block_class) begin
                  report_error($sformatf("block_class got %0d want %0d",
                                         rsp_word.block_class, want.block_class));
               end
               if (rsp_word.block_index !== want.block_index) begin
                  report_error($sformatf("block_index got %0d want %0d",
                                         rsp_word.block_index, want.block_index));
               end
            end
         end
         if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      for (int c = 0; c < POOLED_CLASSES; c++) begin
         stack_top[c]   = POOL_BLOCKS;
         fresh_count[c] = 0;
         issued[c]      = 0;
      end
      error_count    = 0;
      stall_cycles   = 0;
      large_pushes   = 0;
      drain_next     = 1'b0;
      phase_idle_pct = 0;

      // Size boundaries, sentinel and oversized requests.
      add_word(make_alloc(0));
      add_word(make_alloc(-32768));
      add_word(make_alloc(-1));
      add_word(make_alloc(1));
      add_word(make_alloc(SMALL_MAX_WORDS));
      add_word(make_alloc(SMALL_MAX_WORDS + 1));
      add_word(make_alloc(MEDIUM_MAX_WORDS));
      add_word(make_alloc(MEDIUM_MAX_WORDS + 1));
      add_word(make_alloc(LARGE_MAX_WORDS));
      add_word(make_alloc(LARGE_MAX_WORDS + 1));
      add_word(make_alloc(32767));
      // Ignored frees, a never-issued block, and a double free.
      add_word(make_free(CLS_SENTINEL, 5));
      add_word(make_free(CLS_OVERSIZED, POOL_BLOCKS - 1));
      add_word(make_free(7, 0));
      add_word(make_free(CLS_SMALL, POOL_BLOCKS - 1));
      add_word(make_free(CLS_SMALL, 0));
      add_word(make_free(CLS_SMALL, 0));
      add_word(make_free(CLS_MEDIUM, 0));
      add_word(make_free(CLS_LARGE, 512));
      // Pops from the stacks; the doubly freed block links to itself and comes out on every small pop.
      add_word(make_alloc(1));
      add_word(make_alloc(2));
      add_word(make_alloc(1));
      add_word(make_alloc(1));
      add_word(make_alloc(5));
      add_word(make_alloc(40));
      for (int c = 0; c < POOLED_CLASSES; c++) begin
         issued[c] = 4;
      end

      add_mixed(60);

      phase_idle_pct = 67;
      drain_next     = 1'b1;
      add_mixed(60);

      // Run the large pool dry; the stack depth is bounded by the pushes so far.
      phase_idle_pct = 30;
      drain_next     = 1'b1;
      begin
         int sweep;
         sweep = POOL_BLOCKS + large_pushes + 16;
         for (int i = 0; i < sweep; i++) begin
            add_word(make_alloc($urandom_range(MEDIUM_MAX_WORDS + 1, LARGE_MAX_WORDS)));
         end
      end
      issued[2] = POOL_BLOCKS - 1;

      phase_idle_pct = 0;
      add_mixed(60);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         report_error($sformatf("%0d results never arrived", expected_rsps.size()));
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: size_class_block_allocator_top.f
design/scba_pkg.sv
design/scba_ram.sv
design/scba_classify.sv
design/size_class_block_allocator_top.sv
dv/size_class_block_allocator_top_tb.sv
